// ===== src/sfau_pkg.sv =====
package sfau_pkg;

  // frame size limit and the widths that follow from it
  localparam int MAX_FRAME_BYTES = 4096;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES);
  localparam int START_W         = 12;
  localparam int SPAN_W          = START_W + 1;
  localparam int NUM_UNITS       = 6;

  // byte positions of the header and of the packed start fields
  localparam int POS_HEADER = 2;
  localparam int POS_START1 = 4;
  localparam int POS_START2 = 5;
  localparam int POS_START3 = 7;
  localparam int POS_START4 = 8;
  localparam int POS_START5 = 10;

  // header bits
  localparam int HDR_DAC48  = 6;
  localparam int HDR_HALF   = 5;
  localparam int HDR_STEREO = 4;
  localparam int HDR_PS     = 3;

  // crc-16/ccitt
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // sampling rate index codes
  localparam logic [3:0] RATE_48K = 4'd3;
  localparam logic [3:0] RATE_32K = 4'd5;
  localparam logic [3:0] RATE_24K = 4'd6;
  localparam logic [3:0] RATE_16K = 4'd8;

  // surround codes and channel configurations
  localparam logic [2:0] SURR_51    = 3'd1;
  localparam logic [2:0] SURR_71    = 3'd2;
  localparam logic [3:0] CH_MONO    = 4'd1;
  localparam logic [3:0] CH_STEREO  = 4'd2;
  localparam logic [3:0] CH_51      = 4'd6;
  localparam logic [3:0] CH_71      = 4'd7;
  localparam logic [4:0] AAC_OBJ_LC = 5'd2;
  localparam logic [2:0] CFG_960    = 3'd4;

  typedef logic [START_W-1:0] start_t;
  typedef logic [SPAN_W-1:0]  span_t;

  typedef enum logic {
    PH_BYTE,
    PH_FLUSH
  } phase_t;

  // one access unit to be reported
  typedef struct packed {
    logic [2:0]  idx;
    start_t      start;
    start_t      prev_start;
    span_t       stop;
    span_t       limit;
    logic        seen;
    logic        overflow;
    logic [15:0] crc;
    logic [15:0] tail;
    logic [7:0]  hdr;
    logic [2:0]  count;
  } unit_req_t;

  typedef struct packed {
    logic [2:0]  unit_index;
    start_t      unit_offset;
    start_t      unit_length;
    logic        crc_ok;
    logic        bounds_ok;
    logic [3:0]  core_rate_code;
    logic        stereo;
    logic        ps_flag;
    logic [2:0]  surr_cfg;
    logic [15:0] audio_config_word;
    logic        last_unit;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/sfau_in_if.sv =====
interface sfau_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_end;

  modport source(output valid, output data_byte, output frame_end, input ready);
  modport sink(input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== src/sfau_out_if.sv =====
interface sfau_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  unit_index;
  logic [11:0] unit_offset;
  logic [11:0] unit_length;
  logic        crc_ok;
  logic        bounds_ok;
  logic [3:0]  core_rate_code;
  logic        stereo;
  logic        ps_flag;
  logic [2:0]  surr_cfg;
  logic [15:0] audio_config_word;
  logic        last_unit;

  modport source(
    output valid, output unit_index, output unit_offset, output unit_length,
    output crc_ok, output bounds_ok, output core_rate_code, output stereo,
    output ps_flag, output surr_cfg, output audio_config_word,
    output last_unit, input ready
  );
  modport sink(
    input valid, input unit_index, input unit_offset, input unit_length,
    input crc_ok, input bounds_ok, input core_rate_code, input stereo,
    input ps_flag, input surr_cfg, input audio_config_word,
    input last_unit, output ready
  );
endinterface

// ===== src/sfau_unit_eval.sv =====
module sfau_unit_eval import sfau_pkg::*; (
  input  unit_req_t req,
  output result_t   res
);

  logic [3:0] rate;
  logic [3:0] chan;
  logic       first_ok;
  logic       room_ok;
  logic       bounds;
  logic       match;

  always_comb begin
    case ({req.hdr[HDR_HALF], req.hdr[HDR_DAC48]})
      2'b00:   rate = RATE_32K;
      2'b01:   rate = RATE_48K;
      2'b10:   rate = RATE_16K;
      default: rate = RATE_24K;
    endcase

    case (req.hdr[2:0])
      SURR_51: chan = CH_51;
      SURR_71: chan = CH_71;
      default: chan = req.hdr[HDR_STEREO] ? CH_STEREO : CH_MONO;
    endcase

    // the first unit has no predecessor to compare against
    first_ok = (req.idx == 3'd0) || (req.start > req.prev_start);
    room_ok  = req.stop >= (span_t'(req.start) + span_t'(2));
    bounds   = first_ok && room_ok && (req.stop <= req.limit) && !req.overflow;
    match    = (~req.crc) == req.tail;

    res.unit_index        = req.idx;
    res.unit_offset       = req.start;
    res.unit_length       = req.stop[START_W-1:0] - req.start;
    res.crc_ok            = req.seen && bounds && match;
    res.bounds_ok         = bounds;
    res.core_rate_code    = rate;
    res.stereo            = req.hdr[HDR_STEREO];
    res.ps_flag           = req.hdr[HDR_PS];
    res.surr_cfg          = req.hdr[2:0];
    res.audio_config_word = {AAC_OBJ_LC, rate, chan, CFG_960};
    res.last_unit         = ({1'b0, req.idx} + 4'd1) == {1'b0, req.count};
  end

endmodule

// ===== src/sfau_out_stage.sv =====
module sfau_out_stage import sfau_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_req,
  input  result_t           load_res,
  output logic              slot_free,
  sfau_out_if.source        out_ch
);

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;
  logic    load;

  assign slot_free = !valid_r || out_ch.ready;
  assign load      = load_req && slot_free;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= load_res;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.unit_index        = res_r.unit_index;
  assign out_ch.unit_offset       = res_r.unit_offset;
  assign out_ch.unit_length       = res_r.unit_length;
  assign out_ch.crc_ok            = res_r.crc_ok;
  assign out_ch.bounds_ok         = res_r.bounds_ok;
  assign out_ch.core_rate_code    = res_r.core_rate_code;
  assign out_ch.stereo            = res_r.stereo;
  assign out_ch.ps_flag           = res_r.ps_flag;
  assign out_ch.surr_cfg          = res_r.surr_cfg;
  assign out_ch.audio_config_word = res_r.audio_config_word;
  assign out_ch.last_unit         = res_r.last_unit;

endmodule

// ===== src/superframe_au_split_crc_check.sv =====
// Splits an audio superframe, fed one byte per transfer with frame_end on the
// last byte, into its 2, 3, 4 or 6 access units as selected by the header in
// byte 2, and checks the CRC-16 (poly 0x1021, init 0xFFFF, inverted) that
// closes each unit. One result is given per unit, with its offset, length,
// CRC and bounds flags and the audio config word built from the header. A
// byte is taken into an input register and handled from there while the
// previous result may still wait in the output register. Ordinary bytes
// stream at one per clock; a byte that reaches the start of one or more
// new units is held while it closes them one at a time, as the single
// result register is loaded at most once a cycle and only when free.
// After the frame_end byte each unit still open is reported in turn, the
// last report also clearing the frame state, which is cleared alone when
// none is open. Frames longer than 4096 bytes have their surplus bytes
// dropped and the units still open reported as out of bounds.
module superframe_au_split_crc_check import sfau_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sfau_in_if.sink    in_ch,
  sfau_out_if.source out_ch
);

  // input register
  logic       hv_r;
  logic [7:0] b_r;
  logic       fe_r;
  logic       take;
  logic       done;

  // frame state
  phase_t            phase_r,  phase_nxt;
  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [7:0]        hdr_r,    hdr_nxt;
  logic [7:0]        prev_r,   prev_nxt;
  start_t            st_r      [NUM_UNITS];
  start_t            st_nxt    [NUM_UNITS];
  logic [2:0]        ucnt_r,   ucnt_nxt;
  logic [2:0]        cur_r,    cur_nxt;
  logic [15:0]       crc_r,    crc_nxt;
  logic [7:0]        t0_r,     t0_nxt;
  logic [7:0]        t1_r,     t1_nxt;
  logic              ov_r,     ov_nxt;
  logic              first_r,  first_nxt;

  // state with this byte's header and start fields applied
  logic [7:0]  hdr_e;
  start_t      st_e [NUM_UNITS];
  logic [2:0]  ucnt_e;
  logic [2:0]  cur_e;
  logic [15:0] crc_e;
  logic [7:0]  t0_e;
  logic [7:0]  t1_e;
  start_t      hi_field;
  start_t      lo_field;

  logic        apply_pre;
  span_t       p_w;
  start_t      cur_start;
  start_t      nxt_start;
  start_t      prv_start;
  logic        active;
  logic        loop_go;
  logic        feed;

  // end-of-frame reporting
  start_t      f_start;
  start_t      f_prev;
  start_t      f_next;
  span_t       size;
  logic        started;
  logic        f_has;

  unit_req_t   req;
  logic        req_valid;
  result_t     res;
  logic        slot_free;

  function automatic start_t pick_start(input start_t a [NUM_UNITS], input logic [2:0] k);
    start_t v;
    case (k)
      3'd0:    v = a[0];
      3'd1:    v = a[1];
      3'd2:    v = a[2];
      3'd3:    v = a[3];
      3'd4:    v = a[4];
      3'd5:    v = a[5];
      default: v = '0;
    endcase
    return v;
  endfunction

  assign take        = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !hv_r || done;
  assign p_w         = span_t'(pos_r);
  assign apply_pre   = hv_r && (phase_r == PH_BYTE) && !ov_r;
  assign hi_field    = {prev_r, b_r[7:4]};
  assign lo_field    = {prev_r[3:0], b_r};

  // header and start fields, written again on each cycle of the same byte
  always_comb begin
    hdr_e  = hdr_r;
    ucnt_e = ucnt_r;
    cur_e  = cur_r;
    crc_e  = crc_r;
    t0_e   = t0_r;
    t1_e   = t1_r;
    for (int i = 0; i < NUM_UNITS; i++) begin
      st_e[i] = st_r[i];
    end
    if (apply_pre) begin
      if (p_w == span_t'(POS_HEADER)) begin
        hdr_e = b_r;
        // unit count and fixed first start from the rate flags
        if (b_r[HDR_HALF]) begin
          ucnt_e  = b_r[HDR_DAC48] ? 3'd3 : 3'd2;
          st_e[0] = b_r[HDR_DAC48] ? start_t'(6) : start_t'(5);
        end else begin
          ucnt_e  = b_r[HDR_DAC48] ? 3'd6 : 3'd4;
          st_e[0] = b_r[HDR_DAC48] ? start_t'(11) : start_t'(8);
        end
        for (int i = 1; i < NUM_UNITS; i++) begin
          st_e[i] = '0;
        end
        cur_e = 3'd0;
        crc_e = CRC_INIT;
        t0_e  = 8'h00;
        t1_e  = 8'h00;
      end else if (ucnt_r != 3'd0) begin
        // packed 12-bit starts, high nibble first
        if (p_w == span_t'(POS_START1) && ucnt_r > 3'd1) st_e[1] = hi_field;
        if (p_w == span_t'(POS_START2) && ucnt_r > 3'd2) st_e[2] = lo_field;
        if (p_w == span_t'(POS_START3) && ucnt_r > 3'd3) st_e[3] = hi_field;
        if (p_w == span_t'(POS_START4) && ucnt_r > 3'd4) st_e[4] = lo_field;
        if (p_w == span_t'(POS_START5) && ucnt_r > 3'd5) st_e[5] = hi_field;
      end
    end
  end

  // unit boundary detection and result request
  always_comb begin
    cur_start = pick_start(st_e, cur_e);
    nxt_start = (cur_e < 3'd5) ? pick_start(st_e, cur_e + 3'd1) : '0;
    prv_start = (cur_e != 3'd0) ? pick_start(st_e, cur_e - 3'd1) : '0;
    active    = (ucnt_e != 3'd0) && (p_w >= span_t'(st_e[0]));
    // the byte lies at or past the next unit's start: close the current unit
    loop_go   = apply_pre && active && (({1'b0, cur_e} + 4'd1) < {1'b0, ucnt_e}) &&
                (cur_e < 3'd5) && (p_w >= span_t'(nxt_start));
    // the tail byte leaving the two-byte window goes into the crc
    feed      = active && (p_w >= (span_t'(cur_start) + span_t'(2)));

    f_start = pick_start(st_r, cur_r);
    f_prev  = (cur_r != 3'd0) ? pick_start(st_r, cur_r - 3'd1) : '0;
    f_next  = (cur_r < 3'd5) ? pick_start(st_r, cur_r + 3'd1) : '0;
    size    = ov_r ? span_t'(MAX_FRAME_BYTES) : (p_w + span_t'(1));
    started = (ucnt_r != 3'd0) && (p_w >= span_t'(st_r[0]));
    f_has   = cur_r < ucnt_r;

    if (phase_r == PH_BYTE) begin
      req_valid      = loop_go;
      req.idx        = cur_e;
      req.start      = cur_start;
      req.prev_start = prv_start;
      req.stop       = span_t'(nxt_start);
      req.limit      = '1;
      req.seen       = 1'b1;
      req.overflow   = 1'b0;
      req.crc        = crc_e;
      req.tail       = {t0_e, t1_e};
      req.hdr        = hdr_e;
      req.count      = ucnt_e;
    end else begin
      req_valid      = hv_r && f_has;
      req.idx        = cur_r;
      req.start      = f_start;
      req.prev_start = f_prev;
      // the last unit runs to the end of the frame
      req.stop       = (({1'b0, cur_r} + 4'd1) < {1'b0, ucnt_r}) ? span_t'(f_next) : size;
      req.limit      = size;
      req.seen       = started && first_r;
      req.overflow   = ov_r;
      req.crc        = crc_r;
      req.tail       = {t0_r, t1_r};
      req.hdr        = hdr_r;
      req.count      = ucnt_r;
    end
  end

  // sequencer for the held byte
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    prev_nxt  = prev_r;
    ucnt_nxt  = ucnt_r;
    cur_nxt   = cur_r;
    crc_nxt   = crc_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    ov_nxt    = ov_r;
    first_nxt = first_r;
    done      = 1'b0;
    for (int i = 0; i < NUM_UNITS; i++) begin
      st_nxt[i] = st_r[i];
    end

    if (hv_r) begin
      unique case (phase_r)
        PH_BYTE: begin
          if (loop_go) begin
            // report the unit that ends here, then open the next one
            if (slot_free) begin
              hdr_nxt  = hdr_e;
              ucnt_nxt = ucnt_e;
              for (int i = 0; i < NUM_UNITS; i++) begin
                st_nxt[i] = st_e[i];
              end
              cur_nxt = cur_e + 3'd1;
              crc_nxt = CRC_INIT;
              t0_nxt  = 8'h00;
              t1_nxt  = 8'h00;
            end
          end else begin
            // bytes after an overflow are dropped
            if (!ov_r) begin
              hdr_nxt  = hdr_e;
              ucnt_nxt = ucnt_e;
              for (int i = 0; i < NUM_UNITS; i++) begin
                st_nxt[i] = st_e[i];
              end
              cur_nxt = cur_e;
              crc_nxt = feed ? crc16_byte(crc_e, t0_e) : crc_e;
              t0_nxt  = active ? t1_e : t0_e;
              t1_nxt  = active ? b_r : t1_e;
              prev_nxt = b_r;
              if (!fe_r) begin
                if (pos_r == POS_W'(MAX_FRAME_BYTES - 1)) begin
                  ov_nxt = 1'b1;
                end else begin
                  pos_nxt = pos_r + POS_W'(1);
                end
              end
            end
            if (fe_r) begin
              phase_nxt = PH_FLUSH;
              first_nxt = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
        end
        PH_FLUSH: begin
          // open units reported one per free slot; the last clears the frame
          if (f_has && !(slot_free && (({1'b0, cur_r} + 4'd1) == {1'b0, ucnt_r}))) begin
            if (slot_free) begin
              cur_nxt   = cur_r + 3'd1;
              first_nxt = 1'b0;
            end
          end else if (!f_has || slot_free) begin
            phase_nxt = PH_BYTE;
            pos_nxt   = '0;
            prev_nxt  = 8'h00;
            ucnt_nxt  = 3'd0;
            cur_nxt   = 3'd0;
            ov_nxt    = 1'b0;
            crc_nxt   = CRC_INIT;
            t0_nxt    = 8'h00;
            t1_nxt    = 8'h00;
            first_nxt = 1'b0;
            done      = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_BYTE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r    <= 1'b0;
      phase_r <= PH_BYTE;
      pos_r   <= '0;
      hdr_r   <= 8'h00;
      prev_r  <= 8'h00;
      ucnt_r  <= 3'd0;
      cur_r   <= 3'd0;
      crc_r   <= CRC_INIT;
      t0_r    <= 8'h00;
      t1_r    <= 8'h00;
      ov_r    <= 1'b0;
      first_r <= 1'b0;
    end else begin
      if (take) begin
        hv_r <= 1'b1;
      end else if (done) begin
        hv_r <= 1'b0;
      end
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      prev_r  <= prev_nxt;
      ucnt_r  <= ucnt_nxt;
      cur_r   <= cur_nxt;
      crc_r   <= crc_nxt;
      t0_r    <= t0_nxt;
      t1_r    <= t1_nxt;
      ov_r    <= ov_nxt;
      first_r <= first_nxt;
    end
  end

  // byte register and start table carry no reset
  always_ff @(posedge clk) begin
    if (take) begin
      b_r  <= in_ch.data_byte;
      fe_r <= in_ch.frame_end;
    end
    for (int i = 0; i < NUM_UNITS; i++) begin
      st_r[i] <= st_nxt[i];
    end
  end

  sfau_unit_eval u_eval (
    .req (req),
    .res (res)
  );

  sfau_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_req  (req_valid),
    .load_res  (res),
    .slot_free (slot_free),
    .out_ch    (out_ch)
  );

  // the current unit always lies inside the frame's unit count
  a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ucnt_r != 3'd0) |-> (cur_r < ucnt_r))
    else $error("current unit beyond unit count");

  // unit count only takes the values the header can select
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (ucnt_r == 3'd0) || (ucnt_r == 3'd2) || (ucnt_r == 3'd3) ||
    (ucnt_r == 3'd4) || (ucnt_r == 3'd6))
    else $error("illegal unit count");

  // overflow is only raised with the position pinned at the last byte
  a_ovf_pos: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (pos_r == POS_W'(MAX_FRAME_BYTES - 1)))
    else $error("overflow with position below frame limit");

  // a passing crc needs a unit in bounds
  a_crc_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.crc_ok) |-> out_ch.bounds_ok)
    else $error("crc pass on out-of-bounds unit");

  // after the last unit of a frame is loaded, the frame state is cleared
  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (hv_r && (phase_r == PH_FLUSH) && done) |=> ((ucnt_r == 3'd0) && !ov_r))
    else $error("frame state not cleared after frame end");

endmodule

// ===== bench/tb_superframe_au_split_crc_check.sv =====
module tb_superframe_au_split_crc_check;
  import sfau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // run guard, far above what the slowest legal run needs
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned OPEN_END    = 32'hFFFF_FFFF;
  localparam int unsigned RANDOM_BYTES = 320;
  localparam int unsigned HOLD_AT_BYTE = 100;
  localparam int unsigned HOLD_CYCLES  = 300;

  // one byte waiting to go out on the input channel
  typedef struct packed {
    logic [7:0] octet;
    logic       ends_frame;
  } feed_item_t;

  logic clk;
  logic rst_n;

  sfau_in_if  in_ch();
  sfau_out_if out_ch();

  superframe_au_split_crc_check dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  feed_item_t  byte_feed[$];        // bytes still to be offered
  result_t     au_reports_due[$];   // unit reports owed by the block, oldest first

  // splitter state as the block should hold it
  logic [11:0] sf_pos;
  logic [7:0]  sf_hdr;
  logic [7:0]  sf_prev;
  start_t      sf_start[NUM_UNITS];
  logic [2:0]  sf_units;
  logic [2:0]  sf_cur;
  logic [15:0] sf_crc;
  logic [7:0]  sf_tail[2];
  logic        sf_ovf;

  // bookkeeping
  int unsigned err_count;
  int unsigned mism_lines;
  int unsigned bytes_in;
  int unsigned frames_in;
  int unsigned reports_seen;
  int unsigned crc_good_seen;
  int unsigned oob_seen;
  int unsigned cycle_cnt;
  bit          in_taken;

  // sender burst shaping
  int unsigned burst_left;
  int unsigned gap_left;

  // receiver stall pattern and the one long hold-off
  logic [7:0]  stall_pat;
  logic [2:0]  stall_ph;
  int unsigned hold_left;
  bit          hold_done;

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // bitwise crc-16/ccitt, msb first
  function automatic logic [15:0] crc_shift(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ d[k]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // number of units and fixed first start selected by the header byte
  function automatic void header_layout(input logic [7:0] hdr, output int unsigned n,
                                        output int unsigned s0);
    if (hdr[HDR_HALF]) begin
      n  = hdr[HDR_DAC48] ? 3 : 2;
      s0 = hdr[HDR_DAC48] ? 6 : 5;
    end else begin
      n  = hdr[HDR_DAC48] ? 6 : 4;
      s0 = hdr[HDR_DAC48] ? 11 : 8;
    end
  endfunction

  function automatic void unit_restart();
    sf_crc     = CRC_INIT;
    sf_tail[0] = '0;
    sf_tail[1] = '0;
  endfunction

  function automatic void frame_restart();
    sf_pos   = '0;
    sf_prev  = '0;
    sf_units = '0;
    sf_cur   = '0;
    sf_ovf   = 1'b0;
    unit_restart();
  endfunction

  // report for unit idx ending at stop; lim is the frame size where known
  function automatic result_t au_report(input int unsigned idx, input int unsigned stop,
                                        input int unsigned lim, input bit seen);
    result_t     r;
    int unsigned s;
    int unsigned prev_s;
    logic [3:0]  rate;
    logic [3:0]  ch;
    logic [2:0]  surr;
    logic        st;
    bit          bounds;
    bit          match;
    s = sf_start[idx];
    prev_s = (idx == 0) ? 0 : sf_start[idx - 1];
    if (sf_hdr[HDR_HALF]) begin
      rate = sf_hdr[HDR_DAC48] ? RATE_24K : RATE_16K;
    end else begin
      rate = sf_hdr[HDR_DAC48] ? RATE_48K : RATE_32K;
    end
    st   = sf_hdr[HDR_STEREO];
    surr = sf_hdr[2:0];
    if (surr == SURR_51) begin
      ch = CH_51;
    end else if (surr == SURR_71) begin
      ch = CH_71;
    end else begin
      ch = st ? CH_STEREO : CH_MONO;
    end
    bounds = (idx == 0 || s > prev_s) && stop >= s + 2 && stop <= lim && !sf_ovf;
    match  = (~sf_crc) == {sf_tail[0], sf_tail[1]};
    r.unit_index        = idx[2:0];
    r.unit_offset       = start_t'(s);
    r.unit_length       = start_t'(stop - s);
    r.crc_ok            = seen && bounds && match;
    r.bounds_ok         = bounds;
    r.core_rate_code    = rate;
    r.stereo            = st;
    r.ps_flag           = sf_hdr[HDR_PS];
    r.surr_cfg          = surr;
    r.audio_config_word = {AAC_OBJ_LC, rate, ch, CFG_960};
    r.last_unit         = (idx + 1 == sf_units);
    return r;
  endfunction

  // advance the splitter by one accepted byte and queue the reports it causes
  function automatic void au_split_step(input logic [7:0] b, input logic fe);
    int unsigned p;
    int unsigned n;
    int unsigned s0;
    int unsigned sz;
    int unsigned stop;
    logic [11:0] hi;
    logic [11:0] lo;
    bit          started;
    if (!sf_ovf) begin
      p = sf_pos;
      if (p == POS_HEADER) begin
        sf_hdr = b;
        header_layout(b, n, s0);
        sf_units    = n[2:0];
        sf_start[0] = start_t'(s0);
        for (int i = 1; i < NUM_UNITS; i++) sf_start[i] = '0;
        sf_cur = '0;
        unit_restart();
      end else if (sf_units > 0) begin
        hi = {sf_prev, b[7:4]};
        lo = {sf_prev[3:0], b};
        if (p == POS_START1 && sf_units > 1) sf_start[1] = hi;
        if (p == POS_START2 && sf_units > 2) sf_start[2] = lo;
        if (p == POS_START3 && sf_units > 3) sf_start[3] = hi;
        if (p == POS_START4 && sf_units > 4) sf_start[4] = lo;
        if (p == POS_START5 && sf_units > 5) sf_start[5] = hi;
      end
      if (sf_units > 0 && p >= sf_start[0]) begin
        // a byte can close several units at once when starts repeat or go back
        while (sf_cur + 1 < sf_units && sf_cur < 5 && p >= sf_start[sf_cur + 1]) begin
          au_reports_due.push_back(au_report(sf_cur, sf_start[sf_cur + 1], OPEN_END, 1'b1));
          sf_cur++;
          unit_restart();
        end
        // crc runs two bytes behind so the trailing pair stays out of it
        if (p >= sf_start[sf_cur] + 2) sf_crc = crc_shift(sf_crc, sf_tail[0]);
        sf_tail[0] = sf_tail[1];
        sf_tail[1] = b;
      end
      sf_prev = b;
      if (!fe) begin
        if (sf_pos >= MAX_FRAME_BYTES - 1) begin
          sf_ovf = 1'b1;
        end else begin
          sf_pos++;
        end
      end
    end
    if (fe) begin
      sz = sf_ovf ? MAX_FRAME_BYTES : sf_pos + 1;
      started = sf_units > 0 && sf_pos >= sf_start[0];
      for (int unsigned i = sf_cur; i < sf_units; i++) begin
        stop = (i + 1 < sf_units) ? sf_start[i + 1] : sz;
        au_reports_due.push_back(au_report(i, stop, sz, started && i == sf_cur));
      end
      frame_restart();
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // lay out a superframe with the given header and starts, seal unit crcs,
  // optionally flip one payload bit, and queue the first keep bytes
  function automatic void push_frame(input logic [7:0] hdr, input start_t st[NUM_UNITS],
                                     input int unsigned size, input bit seal,
                                     input bit spoil, input int unsigned keep);
    logic [7:0]  fb[];
    int unsigned n;
    int unsigned s0;
    int unsigned stop;
    int unsigned cnt;
    int unsigned k;
    logic [15:0] c;
    fb = new[(size > 11) ? size : 11];
    foreach (fb[j]) fb[j] = $urandom;
    fb[POS_HEADER] = hdr;
    header_layout(hdr, n, s0);
    // packed 12-bit starts, msb first
    if (n > 1) begin
      fb[3] = st[1][11:4];
      fb[4][7:4] = st[1][3:0];
    end
    if (n > 2) begin
      fb[4][3:0] = st[2][11:8];
      fb[5] = st[2][7:0];
    end
    if (n > 3) begin
      fb[6] = st[3][11:4];
      fb[7][7:4] = st[3][3:0];
    end
    if (n > 4) begin
      fb[7][3:0] = st[4][11:8];
      fb[8] = st[4][7:0];
    end
    if (n > 5) begin
      fb[9] = st[5][11:4];
      fb[10][7:4] = st[5][3:0];
    end
    if (seal) begin
      for (int unsigned i = 0; i < n; i++) begin
        stop = (i + 1 < n) ? st[i + 1] : size;
        // only units whose crc pair lies past the start fields get a valid crc
        if (st[i] + 2 <= stop && stop <= size && stop >= 13) begin
          c = CRC_INIT;
          for (k = st[i]; k + 2 < stop; k++) c = crc_shift(c, fb[k]);
          c = ~c;
          fb[stop - 2] = c[15:8];
          fb[stop - 1] = c[7:0];
        end
      end
    end
    if (spoil && size > s0) begin
      k = $urandom_range(s0, size - 1);
      fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    cnt = (keep < size) ? keep : size;
    for (k = 0; k < cnt; k++) byte_feed.push_back('{fb[k], k == cnt - 1});
  endfunction

  // one random superframe: mostly well formed, the rest truncated,
  // with broken starts, or plain noise
  function automatic void random_frame(input bit broken);
    logic [7:0]  hdr;
    start_t      st[NUM_UNITS];
    int unsigned n;
    int unsigned s0;
    int unsigned pos;
    int unsigned v;
    int unsigned mode;
    hdr = $urandom;
    header_layout(hdr, n, s0);
    pos = s0;
    for (int i = 0; i < NUM_UNITS; i++) begin
      st[i] = '0;
      if (i < n) begin
        st[i] = start_t'(pos);
        // zero-payload units now and then, where only the crc pair remains
        pos += ($urandom_range(0, 7) == 0) ? 2 : $urandom_range(3, 12);
      end
    end
    mode = broken ? $urandom_range(0, 2) : 3;
    case (mode)
      0: push_frame(hdr, st, pos, 1'b1, 1'b0, $urandom_range(1, pos - 1));
      1: begin
        v = $urandom_range(1, n - 1);
        case ($urandom_range(0, 3))
          0: st[v] = st[v - 1];
          1: st[v] = st[v - 1] + 1;
          2: st[v] = st[v - 1] - 1;
          default: st[v] = $urandom;
        endcase
        push_frame(hdr, st, pos, 1'b1, 1'b0, pos);
      end
      2: begin
        foreach (st[i]) st[i] = $urandom;
        pos = $urandom_range(1, 24);
        push_frame(hdr, st, pos, 1'b0, 1'b0, pos);
      end
      default: push_frame(hdr, st, pos, 1'b1, $urandom_range(0, 3) == 0, pos);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // clock, reset and sequencing
  // ---------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    start_t      st[NUM_UNITS];
    int unsigned base;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.frame_end = 1'b0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    err_count       = 0;
    mism_lines      = 0;
    bytes_in        = 0;
    frames_in       = 0;
    reports_seen    = 0;
    crc_good_seen   = 0;
    oob_seen        = 0;
    in_taken        = 1'b0;
    burst_left      = 8;
    gap_left        = 0;
    stall_pat       = 8'hFF;
    stall_ph        = '0;
    hold_left       = 0;
    hold_done       = 1'b0;

    // predictor starts from the reset state
    sf_hdr = '0;
    foreach (sf_start[i]) sf_start[i] = '0;
    frame_restart();

    // directed: frames that end before the header, at the header, a short
    // two-unit frame whose crc pairs are not sealed, and a repeated start
    foreach (st[i]) st[i] = '0;
    push_frame(8'h00, st, 1, 1'b0, 1'b0, 1);
    push_frame(8'h00, st, 2, 1'b0, 1'b0, 2);
    push_frame(8'h62, st, 3, 1'b0, 1'b0, 3);
    st[0] = 12'd5;
    st[1] = 12'd7;
    push_frame(8'h30, st, 9, 1'b1, 1'b0, 9);
    st[0] = 12'd6;
    st[1] = 12'd6;
    st[2] = 12'd9;
    push_frame(8'hE9, st, 12, 1'b1, 1'b0, 12);

    // random frames, about 3 in 10 broken
    base = byte_feed.size();
    while (byte_feed.size() - base < RANDOM_BYTES) random_frame($urandom_range(0, 9) < 3);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain: every byte taken and every report back
    while (byte_feed.size() != 0 || in_ch.valid || au_reports_due.size() != 0) begin
      @(posedge clk);
    end
    // allow the block to settle, catching any stray report
    repeat (20) @(posedge clk);

    $display("covered %0d superframes in %0d bytes, %0d unit reports checked",
             frames_in, bytes_in, reports_seen);
    $display("of those %0d had a good crc and %0d were out of bounds",
             crc_good_seen, oob_seen);
    if (err_count == 0) begin
      $display("** superframe_au_split_crc_check: PASSED **");
    end else begin
      $display("** superframe_au_split_crc_check: FAILED **");
    end
    $finish;
  end

  // run guard
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d reports still owed", cycle_cnt,
             au_reports_due.size());
    $display("** superframe_au_split_crc_check: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // every accepted byte goes through the predictor at the edge that takes it
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      au_split_step(in_ch.data_byte, in_ch.frame_end);
      in_taken = 1'b1;
      bytes_in++;
      if (in_ch.frame_end) frames_in++;
    end
  end

  // sender: bursts of random length with random gaps, a gap of zero
  // being common so that long back-to-back runs occur
  always @(negedge clk) begin
    feed_item_t it;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      in_taken = 1'b0;
      if (gap_left != 0 || byte_feed.size() == 0) begin
        if (gap_left != 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        it = byte_feed.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= it.octet;
        in_ch.frame_end <= it.ends_frame;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------

  // receiver: walks an 8-bit ready pattern, now and then picking a new one;
  // once, well into the random frames, it holds off long enough that the
  // block has to stall its input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= stall_pat[stall_ph];
      stall_ph     <= stall_ph + 3'd1;
      if (stall_ph == 3'd7 && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pat <= 8'hFF;
          1: stall_pat <= $urandom;
          default: stall_pat <= 8'h11;
        endcase
      end
    end
  end

  function automatic void check_field(input string nm, input logic [2:0] idx,
                                      input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      err_count++;
      if (mism_lines < 100) begin
        mism_lines++;
        $display("%0t: unit %0d %s expected 0x%0h got 0x%0h", $time, idx, nm, want, got);
      end
    end
  endfunction

  // compare each report with the oldest one owed
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      reports_seen++;
      if (out_ch.crc_ok === 1'b1) crc_good_seen++;
      if (out_ch.bounds_ok === 1'b0) oob_seen++;
      if (au_reports_due.size() == 0) begin
        err_count++;
        $display("%0t: unit report expected none got unit %0d offset %0d length %0d",
                 $time, out_ch.unit_index, out_ch.unit_offset, out_ch.unit_length);
      end else begin
        want = au_reports_due.pop_front();
        check_field("unit_index", want.unit_index, want.unit_index, out_ch.unit_index);
        check_field("unit_offset", want.unit_index, want.unit_offset, out_ch.unit_offset);
        check_field("unit_length", want.unit_index, want.unit_length, out_ch.unit_length);
        check_field("crc_ok", want.unit_index, want.crc_ok, out_ch.crc_ok);
        check_field("bounds_ok", want.unit_index, want.bounds_ok, out_ch.bounds_ok);
        check_field("core_rate_code", want.unit_index, want.core_rate_code,
                    out_ch.core_rate_code);
        check_field("stereo", want.unit_index, want.stereo, out_ch.stereo);
        check_field("ps_flag", want.unit_index, want.ps_flag, out_ch.ps_flag);
        check_field("surr_cfg", want.unit_index, want.surr_cfg, out_ch.surr_cfg);
        check_field("audio_config_word", want.unit_index, want.audio_config_word,
                    out_ch.audio_config_word);
        check_field("last_unit", want.unit_index, want.last_unit, out_ch.last_unit);
      end
    end
  end

endmodule
